// ----- design/sorted_priority_queue_defines.svh -----
// Assertion macros for the sorted priority queue checker.
// Clocked on aclk, disabled while aresetn is low; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package spq_pkg;

    localparam int VALUE_W   = 32;
    localparam int PRIO_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int ECOUNT_W  = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    typedef struct packed {
        logic load_req;
        logic exec;
    } cmd_t;

endpackage

`default_nettype wire

// ----- design/spq_ctrl.sv -----
// Controller for the sorted priority queue: request capture and result handshake.
// Depends on spq_pkg; drives the command struct into spq_datapath.
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output cmd_t      cmd
);

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold until the result register is free
                if (out_free) begin
                    cmd.exec      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/spq_datapath.sv -----
// Datapath for the sorted priority queue: request register, sorted cell row,
// occupancy counter and result register. Depends on spq_pkg; driven by spq_ctrl.
`default_nettype none

module spq_datapath
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int CNT_W    = 5
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cmd_t                 cmd,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    output logic      [M_TDATA_W-1:0] m_tdata
);

    logic                kind_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [PRIO_W-1:0]   prio_reg;

    logic [VALUE_W-1:0]  val_reg  [CAPACITY];
    logic [PRIO_W-1:0]   pri_reg  [CAPACITY];
    logic [VALUE_W-1:0]  val_next [CAPACITY];
    logic [PRIO_W-1:0]   pri_next [CAPACITY];

    logic [VALUE_W-1:0]  up_val   [CAPACITY];
    logic [PRIO_W-1:0]   up_pri   [CAPACITY];
    logic [VALUE_W-1:0]  dn_val   [CAPACITY];
    logic [PRIO_W-1:0]   dn_pri   [CAPACITY];
    logic [CAPACITY-1:0] after;
    logic [CAPACITY-1:0] up_after;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W+4:0]    count_ext;
    logic                full, empty;
    logic                do_insert, do_remove;

    logic [VALUE_W-1:0]  head_reg, head_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ECOUNT_W-1:0] ecount_reg, ecount_next;

    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign do_insert = cmd.exec && (kind_reg == KIND_INSERT) && !full;
    assign do_remove = cmd.exec && (kind_reg == KIND_REMOVE) && !empty;

    genvar g;
    for (g = 0; g < CAPACITY; g++) begin : g_link
        // new entry goes behind every held entry of lower or equal priority
        assign after[g] = (CNT_W'(g) >= count_reg) || (pri_reg[g] > prio_reg);
        if (g == 0) begin : g_first
            assign up_after[g] = 1'b0;
            assign up_val[g]   = value_reg;
            assign up_pri[g]   = prio_reg;
        end else begin : g_mid
            assign up_after[g] = after[g-1];
            assign up_val[g]   = val_reg[g-1];
            assign up_pri[g]   = pri_reg[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign dn_val[g] = val_reg[g];
            assign dn_pri[g] = pri_reg[g];
        end else begin : g_body
            assign dn_val[g] = val_reg[g+1];
            assign dn_pri[g] = pri_reg[g+1];
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            val_next[i] = val_reg[i];
            pri_next[i] = pri_reg[i];
            if (do_insert && after[i]) begin
                if (up_after[i]) begin
                    val_next[i] = up_val[i];
                    pri_next[i] = up_pri[i];
                end else begin
                    val_next[i] = value_reg;
                    pri_next[i] = prio_reg;
                end
            end else if (do_remove) begin
                val_next[i] = dn_val[i];
                pri_next[i] = dn_pri[i];
            end
        end
    end

    always_comb begin
        count_next  = count_reg;
        head_next   = '0;
        status_next = STAT_OK;
        priority if (do_insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_remove) begin
            count_next = count_reg - CNT_W'(1);
            head_next  = val_reg[0];
        end else if (kind_reg == KIND_INSERT) begin
            status_next = STAT_FULL;
        end else begin
            status_next = STAT_UNDERFLOW;
        end
        count_ext   = {5'b0, count_next};
        ecount_next = count_ext[ECOUNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.exec) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            kind_reg  <= s_tuser;
            value_reg <= s_tdata[VALUE_W-1:0];
            prio_reg  <= s_tdata[VALUE_W+PRIO_W-1:VALUE_W];
        end
        if (cmd.exec) begin
            head_reg   <= head_next;
            status_reg <= status_next;
            ecount_reg <= ecount_next;
            for (int i = 0; i < CAPACITY; i++) begin
                val_reg[i] <= val_next[i];
                pri_reg[i] <= pri_next[i];
            end
        end
    end

    assign m_tdata = {1'b0, ecount_reg, status_reg, head_reg};

endmodule

`default_nettype wire

// ----- design/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: controller plus datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
//  channel | dir | tdata (low bit up)                          | tuser
//  s_      | in  | value[31:0] priority_req[39:32]             | kind (0 insert, 1 remove)
//  m_      | out | head_value[31:0] status[33:32]              | none
//          |     | entry_count[38:34] pad[39]                  |
//
// Each request is first captured into the request register, then shifts the row of
// CAPACITY sorted cells, which all update in parallel.
// One request is in flight at a time; s_tready drops while the shift is pending.
// A result waiting on m_tready holds off the shift until the output register frees.
// Synchronous active-low reset empties the queue; entry contents are not cleared.
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // value, priority_req
    input  wire logic                 s_tuser,  // kind
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata   // head_value, status, entry_count, pad
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    cmd_t cmd;

    spq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ----- design/spq_checker.sv -----
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_defines.svh.
`default_nettype none

`include "sorted_priority_queue_defines.svh"

module spq_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    localparam logic [ECOUNT_W-1:0] FULL_COUNT = ECOUNT_W'(CAPACITY % 32);

    logic [VALUE_W-1:0]  head_value;
    logic [STATUS_W-1:0] status;
    logic [ECOUNT_W-1:0] entry_count;

    assign head_value  = m_tdata[VALUE_W-1:0];
    assign status      = m_tdata[VALUE_W+STATUS_W-1:VALUE_W];
    assign entry_count = m_tdata[VALUE_W+STATUS_W+ECOUNT_W-1:VALUE_W+STATUS_W];

    `SPQ_ASSERT_NOW(a_status_code, m_tvalid,
        status == STAT_OK || status == STAT_UNDERFLOW || status == STAT_FULL,
        "spq: undefined status code")

    `SPQ_ASSERT_NOW(a_head_zero, m_tvalid && status != STAT_OK,
        head_value == '0, "spq: nonzero head_value on underflow or full")

    `SPQ_ASSERT_NOW(a_full_count, m_tvalid && status == STAT_FULL,
        entry_count == FULL_COUNT, "spq: full reported below capacity")

    `SPQ_ASSERT_NOW(a_underflow_count, m_tvalid && status == STAT_UNDERFLOW,
        entry_count == '0, "spq: underflow reported with entries held")

    `SPQ_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "spq: stalled result dropped or changed")

endmodule

bind sorted_priority_queue spq_checker #(
    .CAPACITY (CAPACITY)
) u_spq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- dv/spq_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the sorted priority queue: watches both stream channels,
// keeps a sorted model of the held entries and compares every result.
// Depends on spq_pkg for field widths, kind and status codes.

module spq_scoreboard
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // value, priority_req
    input  logic                 s_tuser,  // kind
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,  // head_value, status, entry_count, pad
    output int                   fail_count,
    output int                   pending,
    output int                   full_count,
    output int                   underflow_count
);

    typedef struct packed {
        logic [VALUE_W-1:0]  head;
        logic [STATUS_W-1:0] status;
        logic [ECOUNT_W-1:0] count;
    } outcome_t;

    logic [VALUE_W-1:0] held_value [CAPACITY];
    logic [PRIO_W-1:0]  held_prio  [CAPACITY];
    int                 held;
    outcome_t           awaited [$];

    function automatic outcome_t apply_request(logic kind, logic [VALUE_W-1:0] value,
                                               logic [PRIO_W-1:0] prio);
        outcome_t res;
        int       pos;
        res = '0;
        res.status = STAT_OK;
        if (kind == KIND_INSERT) begin
            if (held >= CAPACITY) begin
                res.status = STAT_FULL;
            end else begin
                pos = 0;
                while (pos < held && held_prio[pos] <= prio)
                    pos++;
                for (int i = held; i > pos; i--) begin
                    held_value[i] = held_value[i-1];
                    held_prio[i]  = held_prio[i-1];
                end
                held_value[pos] = value;
                held_prio[pos]  = prio;
                held++;
            end
        end else if (held == 0) begin
            res.status = STAT_UNDERFLOW;
        end else begin
            res.head = held_value[0];
            for (int i = 1; i < held; i++) begin
                held_value[i-1] = held_value[i];
                held_prio[i-1]  = held_prio[i];
            end
            held--;
        end
        res.count = ECOUNT_W'(held);
        return res;
    endfunction

    function automatic void compare_field(string name, logic [VALUE_W-1:0] want,
                                          logic [VALUE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        if (!aresetn) begin
            held            = 0;
            fail_count      = 0;
            full_count      = 0;
            underflow_count = 0;
            awaited.delete();
        end else begin
            if (s_tvalid && s_tready)
                awaited.push_back(apply_request(s_tuser, s_tdata[VALUE_W-1:0],
                                                s_tdata[VALUE_W +: PRIO_W]));
            if (m_tvalid && m_tready) begin
                got.head   = m_tdata[VALUE_W-1:0];
                got.status = m_tdata[VALUE_W +: STATUS_W];
                got.count  = m_tdata[VALUE_W+STATUS_W +: ECOUNT_W];
                if (got.status == STAT_FULL)
                    full_count++;
                if (got.status == STAT_UNDERFLOW)
                    underflow_count++;
                if (awaited.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual 0x%0h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = awaited.pop_front();
                    compare_field("head_value", want.head, got.head);
                    compare_field("status", VALUE_W'(want.status), VALUE_W'(got.status));
                    compare_field("entry_count", VALUE_W'(want.count), VALUE_W'(got.count));
                end
            end
        end
        pending <= awaited.size();
    end

endmodule

// ----- dv/sorted_priority_queue_tb.sv -----
`timescale 1ns / 1ps
// Top of the sorted priority queue testbench: clock, reset, request stimulus
// and handshake pressure. Depends on spq_pkg, spq_scoreboard and the block.

module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int CAPACITY = 16;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // value, priority_req
    logic                 s_tuser  = KIND_INSERT;  // kind
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;  // head_value, status, entry_count, pad

    int fail_count;
    int pending;
    int full_count;
    int underflow_count;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int insert_sent = 0;
    int remove_sent = 0;

    always #5 aclk = ~aclk;

    sorted_priority_queue #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    spq_scoreboard #(
        .CAPACITY(CAPACITY)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .fail_count     (fail_count),
        .pending        (pending),
        .full_count     (full_count),
        .underflow_count(underflow_count)
    );

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic offer_request(logic kind, logic [VALUE_W-1:0] value,
                                 logic [PRIO_W-1:0] prio);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {prio, value};
        do @(posedge aclk); while (!s_tready);
        if (kind == KIND_INSERT)
            insert_sent++;
        else
            remove_sent++;
    endtask

    task automatic run_random(int n);
        int          ins_pct;
        logic        kind;
        logic [7:0]  prio;
        ins_pct = 50;
        for (int k = 0; k < n; k++) begin
            // drift the fill level: fill up, drain, or hover
            if (k % 20 == 0)
                case ($urandom_range(2))
                    0: ins_pct = 80;
                    1: ins_pct = 25;
                    default: ins_pct = 50;
                endcase
            kind = ($urandom_range(99) < ins_pct) ? KIND_INSERT : KIND_REMOVE;
            // narrow priorities force ties
            prio = $urandom_range(1) ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom_range(255));
            offer_request(kind, $urandom, prio);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        offer_request(KIND_REMOVE, 32'h0, 8'h0);
        offer_request(KIND_INSERT, 32'h7fff_ffff, 8'd255);
        offer_request(KIND_INSERT, 32'hffff_ffff, 8'd255);
        offer_request(KIND_INSERT, 32'h8000_0000, 8'd0);
        for (int i = 0; i < CAPACITY - 3; i++)
            offer_request(KIND_INSERT, $urandom, PRIO_W'((i * 37) % 256));
        offer_request(KIND_INSERT, 32'h1234_5678, 8'd0);
        offer_request(KIND_REMOVE, 32'hffff_ffff, 8'hff);

        run_random(110);
        idle_pct  <= 79;
        run_random(110);
        idle_pct  <= 0;
        stall_pct <= 79;
        run_random(110);
        idle_pct  <= 22;
        stall_pct <= 22;
        run_random(110);
        s_tvalid  <= 1'b0;

        @(negedge aclk);
        while (pending != 0)
            @(negedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d inserts and %0d removes under four handshake pressure mixes,",
                 insert_sent, remove_sent);
        $display("with %0d full drops and %0d underflows returned.", full_count, underflow_count);
        if (fail_count == 0)
            $display("sorted_priority_queue_tb OK");
        else
            $display("sorted_priority_queue_tb NOT OK");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("sorted_priority_queue_tb NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/spq_pkg.sv
design/spq_ctrl.sv
design/spq_datapath.sv
design/sorted_priority_queue.sv
design/spq_checker.sv
dv/spq_checker.sv
dv/sorted_priority_queue_tb.sv
